>>> hw/rtl/zna_pkg.sv
`timescale 1ns / 1ps

package zna_pkg;

   localparam int FUNC_W    = 1;
   localparam int SIZE_W    = 17;
   localparam int TAG_W     = 8;
   localparam int ADDR_W    = 16;
   localparam int STATUS_W  = 3;
   localparam int MINFRAG_W = 17;
   localparam int BYTES_W   = 17;

   localparam logic [MINFRAG_W-1:0] MINFRAG_RESET = 17'd64;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO_TAG    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NULL        = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_BLOCK   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 3'd5;

   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
   localparam logic [OP_W-1:0] OP_IDLE    = 4'd1;
   localparam logic [OP_W-1:0] OP_CLR     = 4'd2;
   localparam logic [OP_W-1:0] OP_INIT    = 4'd3;
   localparam logic [OP_W-1:0] OP_A_EVAL  = 4'd4;
   localparam logic [OP_W-1:0] OP_A_FOUND = 4'd5;
   localparam logic [OP_W-1:0] OP_A_BASE  = 4'd6;
   localparam logic [OP_W-1:0] OP_F_CHK   = 4'd7;
   localparam logic [OP_W-1:0] OP_F_PREV  = 4'd8;
   localparam logic [OP_W-1:0] OP_F_NEXT  = 4'd9;
   localparam logic [OP_W-1:0] OP_SETPREV = 4'd10;
   localparam logic [OP_W-1:0] OP_DONE    = 4'd11;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } zna_cmd_type;

   typedef struct packed {
      logic req_fire;
      logic is_free;
      logic pre_done;
      logic clr_last;
      logic found;
      logic fail;
      logic split;
      logic chk_err;
      logic merge;
      logic rsp_free;
   } zna_stat_type;

endpackage

>>> hw/rtl/zna_req_if.sv
`timescale 1ns / 1ps

interface zna_req_if import zna_pkg::*;;
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [SIZE_W-1:0]   req_size;
   logic [TAG_W-1:0]    alloc_tag;
   logic [ADDR_W-1:0]   block_addr;

   modport source (output valid, func, req_size, alloc_tag, block_addr, input ready);
   modport sink (input valid, func, req_size, alloc_tag, block_addr, output ready);
endinterface

>>> hw/rtl/zna_rsp_if.sv
`timescale 1ns / 1ps

interface zna_rsp_if import zna_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   user_addr;
   logic [BYTES_W-1:0]  granted_bytes;

   modport source (output valid, status, user_addr, granted_bytes, input ready);
   modport sink (input valid, status, user_addr, granted_bytes, output ready);
endinterface

>>> hw/rtl/zna_ctrl.sv
`timescale 1ns / 1ps

module zna_ctrl import zna_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  zna_stat_type stat,
   output zna_cmd_type  cmd
);

   localparam logic [4:0] S_CLR       = 5'd0;
   localparam logic [4:0] S_INIT      = 5'd1;
   localparam logic [4:0] S_IDLE      = 5'd2;
   localparam logic [4:0] S_A_WAIT    = 5'd3;
   localparam logic [4:0] S_A_EVAL    = 5'd4;
   localparam logic [4:0] S_A_FOUND   = 5'd5;
   localparam logic [4:0] S_A_ON_WAIT = 5'd6;
   localparam logic [4:0] S_A_ON_WR   = 5'd7;
   localparam logic [4:0] S_A_BASE    = 5'd8;
   localparam logic [4:0] S_F_WAIT    = 5'd9;
   localparam logic [4:0] S_F_CHK     = 5'd10;
   localparam logic [4:0] S_F_P_WAIT  = 5'd11;
   localparam logic [4:0] S_F_P_CHK   = 5'd12;
   localparam logic [4:0] S_F_PN_WAIT = 5'd13;
   localparam logic [4:0] S_F_PN_WR   = 5'd14;
   localparam logic [4:0] S_F_N_WAIT  = 5'd15;
   localparam logic [4:0] S_F_N_CHK   = 5'd16;
   localparam logic [4:0] S_F_NN_WAIT = 5'd17;
   localparam logic [4:0] S_F_NN_WR   = 5'd18;
   localparam logic [4:0] S_DONE      = 5'd19;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_CLR: begin
            cmd.op = OP_CLR;
            if (stat.clr_last) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.op   = OP_INIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.op = OP_IDLE;
            if (stat.req_fire) begin
               if (stat.pre_done) begin
                  state_in = S_DONE;
               end else if (stat.is_free) begin
                  state_in = S_F_WAIT;
               end else begin
                  state_in = S_A_WAIT;
               end
            end
         end
         S_A_WAIT: state_in = S_A_EVAL;
         S_A_EVAL: begin
            cmd.op = OP_A_EVAL;
            if (stat.found) begin
               state_in = S_A_FOUND;
            end else if (stat.fail) begin
               state_in = S_DONE;
            end else begin
               state_in = S_A_WAIT;
            end
         end
         S_A_FOUND: begin
            cmd.op   = OP_A_FOUND;
            state_in = stat.split ? S_A_ON_WAIT : S_A_BASE;
         end
         S_A_ON_WAIT: state_in = S_A_ON_WR;
         S_A_ON_WR: begin
            cmd.op   = OP_SETPREV;
            state_in = S_A_BASE;
         end
         S_A_BASE: begin
            cmd.op   = OP_A_BASE;
            state_in = S_DONE;
         end
         S_F_WAIT: state_in = S_F_CHK;
         S_F_CHK: begin
            cmd.op   = OP_F_CHK;
            state_in = stat.chk_err ? S_DONE : S_F_P_WAIT;
         end
         S_F_P_WAIT: state_in = S_F_P_CHK;
         S_F_P_CHK: begin
            cmd.op   = OP_F_PREV;
            state_in = stat.merge ? S_F_PN_WAIT : S_F_N_WAIT;
         end
         S_F_PN_WAIT: state_in = S_F_PN_WR;
         S_F_PN_WR: begin
            cmd.op   = OP_SETPREV;
            state_in = S_F_N_WAIT;
         end
         S_F_N_WAIT: state_in = S_F_N_CHK;
         S_F_N_CHK: begin
            cmd.op   = OP_F_NEXT;
            state_in = stat.merge ? S_F_NN_WAIT : S_DONE;
         end
         S_F_NN_WAIT: state_in = S_F_NN_WR;
         S_F_NN_WR: begin
            cmd.op   = OP_SETPREV;
            state_in = S_DONE;
         end
         S_DONE: begin
            cmd.op = OP_DONE;
            if (stat.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/zna_datapath.sv
`timescale 1ns / 1ps

module zna_datapath import zna_pkg::*; #(
   parameter int ZONE_BYTES   = 65536,
   parameter int HEADER_BYTES = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  zna_cmd_type          cmd,
   output zna_stat_type         stat,
   zna_req_if.sink              req,
   zna_rsp_if.source            rsp,
   input  logic                 csr_wr_en,
   input  logic [MINFRAG_W-1:0] csr_wr_data
);

   localparam int GRANS = ZONE_BYTES / 8;
   localparam int SENT  = GRANS;
   localparam int GW    = $clog2(GRANS + 1);
   localparam int IW    = $clog2(GRANS);
   localparam int SW    = $clog2(GRANS * 8 + 1);
   localparam int CW    = (SW > 18) ? SW : 18;
   localparam int NW    = GW + 2;
   localparam int QW    = GW + 2;
   localparam int PW    = (GW > 13) ? GW + 1 : 14;
   localparam int UW    = (GW + 4 > 16) ? GW + 4 : 16;
   localparam int BW    = (SW > 17) ? SW : 17;
   localparam int EW    = 1 + TAG_W + SW + GW;

   logic [EW-1:0] mem [GRANS];

   logic [GW-1:0]        addr_ff, addr_in;
   logic [EW-1:0]        rd_ff;
   logic                 rd_sent_ff;
   logic [IW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [GW-1:0]        rover_ff, rover_in;
   logic [GW-1:0]        sent_prev_ff, sent_prev_in;
   logic [MINFRAG_W-1:0] min_frag_ff;
   logic [CW-1:0]        need_ff, need_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [GW-1:0]        cur_ff, cur_in;
   logic [GW-1:0]        base_ff, base_in;
   logic [GW-1:0]        start_ff, start_in;
   logic [TAG_W-1:0]     base_tag_ff, base_tag_in;
   logic [SW-1:0]        base_size_ff, base_size_in;
   logic [GW-1:0]        base_prev_ff, base_prev_in;
   logic                 first_ff, first_in;
   logic                 follow_ff, follow_in;
   logic [QW-1:0]        guard_ff, guard_in;
   logic [GW-1:0]        g_ff, g_in;
   logic [SW-1:0]        g_size_ff, g_size_in;
   logic [GW-1:0]        g_prev_ff, g_prev_in;
   logic [GW-1:0]        link_ff, link_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [ADDR_W-1:0]    res_addr_ff, res_addr_in;
   logic [BYTES_W-1:0]   res_bytes_ff, res_bytes_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [BYTES_W-1:0]   rsp_bytes_ff, rsp_bytes_in;

   logic                 d_id;
   logic [TAG_W-1:0]     d_tag;
   logic [SW-1:0]        d_size;
   logic [GW-1:0]        d_prev;

   logic                 wr_en;
   logic [GW-1:0]        wr_addr;
   logic [EW-1:0]        wr_data;

   logic [17:0]          need18;
   logic [ADDR_W-1:0]    off;
   logic [PW-1:0]        g_wide;
   logic                 not_blk;
   logic [TAG_W-1:0]     eb_tag;
   logic [SW-1:0]        eb_size;
   logic [GW-1:0]        eb_prev;
   logic [GW-1:0]        start_eff;
   logic [GW-1:0]        nxt;
   logic [SW-1:0]        extra;
   logic [SW-1:0]        nsz;
   logic [GW-1:0]        nb;
   logic [NW-1:0]        nb_wide;
   logic [UW-1:0]        ua;
   logic [BW-1:0]        gb;

   function automatic logic [GW-1:0] next_of(input logic [GW-1:0] g, input logic [SW-1:0] sz);
      logic [NW-1:0] n;
      n = NW'(g) + NW'(sz >> 3);
      if (g >= GW'(SENT)) begin
         return '0;
      end
      if (n > NW'(SENT)) begin
         return GW'(SENT);
      end
      return n[GW-1:0];
   endfunction

   assign d_id   = rd_sent_ff ? 1'b1 : rd_ff[EW-1];
   assign d_tag  = rd_sent_ff ? TAG_W'(1) : rd_ff[EW-2 -: TAG_W];
   assign d_size = rd_sent_ff ? '0 : rd_ff[GW +: SW];
   assign d_prev = rd_sent_ff ? sent_prev_ff : rd_ff[GW-1:0];

   assign req.ready     = (cmd.op == OP_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.user_addr = rsp_addr_ff;
   assign rsp.granted_bytes = rsp_bytes_ff;

   always_comb begin
      need18  = ({1'b0, req.req_size} + 18'(HEADER_BYTES + 4 + 7)) & ~18'd7;
      off     = req.block_addr - 16'(HEADER_BYTES);
      g_wide  = PW'(off[ADDR_W-1:3]);
      not_blk = (req.block_addr < 16'(HEADER_BYTES)) || (off[2:0] != 3'd0) ||
                (g_wide >= PW'(GRANS));
      eb_tag    = (first_ff || follow_ff) ? d_tag : base_tag_ff;
      eb_size   = (first_ff || follow_ff) ? d_size : base_size_ff;
      eb_prev   = (first_ff || follow_ff) ? d_prev : base_prev_ff;
      start_eff = first_ff ? d_prev : start_ff;
      nxt       = next_of(cur_ff, d_size);
      extra     = base_size_ff - SW'(need_ff);
      nb_wide   = NW'(base_ff) + NW'(need_ff >> 3);
      nb        = nb_wide[GW-1:0];
      ua        = (UW'(base_ff) << 3) + UW'(HEADER_BYTES);
      gb        = BW'(base_size_ff);
      nsz       = '0;

      addr_in       = addr_ff;
      clr_cnt_in    = clr_cnt_ff;
      rover_in      = rover_ff;
      sent_prev_in  = sent_prev_ff;
      need_in       = need_ff;
      tag_in        = tag_ff;
      cur_in        = cur_ff;
      base_in       = base_ff;
      start_in      = start_ff;
      base_tag_in   = base_tag_ff;
      base_size_in  = base_size_ff;
      base_prev_in  = base_prev_ff;
      first_in      = first_ff;
      follow_in     = follow_ff;
      guard_in      = guard_ff;
      g_in          = g_ff;
      g_size_in     = g_size_ff;
      g_prev_in     = g_prev_ff;
      link_in       = link_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_bytes_in  = res_bytes_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = '0;
      stat          = '0;
      stat.rsp_free = !rsp_valid_ff || rsp.ready;
      stat.clr_last = (clr_cnt_ff == IW'(GRANS - 1));

      case (cmd.op)
         OP_CLR: begin
            wr_en      = 1'b1;
            wr_addr    = GW'(clr_cnt_ff);
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         OP_INIT: begin
            wr_en        = 1'b1;
            wr_addr      = '0;
            wr_data      = {1'b1, TAG_W'(0), SW'(GRANS * 8), GW'(SENT)};
            rover_in     = '0;
            sent_prev_in = '0;
         end
         OP_IDLE: begin
            stat.req_fire = req.valid;
            stat.is_free  = (req.func == FUNC_FREE);
            if (req.valid) begin
               need_in       = CW'(need18);
               tag_in        = req.alloc_tag;
               res_status_in = ST_OK;
               res_addr_in   = '0;
               res_bytes_in  = '0;
               first_in      = 1'b1;
               follow_in     = 1'b0;
               guard_in      = '0;
               if (req.func == FUNC_FREE) begin
                  g_in    = GW'(g_wide);
                  addr_in = GW'(g_wide);
                  if (req.block_addr == '0) begin
                     stat.pre_done = 1'b1;
                     res_status_in = ST_NULL;
                  end else if (not_blk) begin
                     stat.pre_done = 1'b1;
                     res_status_in = ST_NOT_BLOCK;
                  end
               end else begin
                  addr_in = rover_ff;
                  cur_in  = rover_ff;
                  base_in = rover_ff;
                  if (req.alloc_tag == '0) begin
                     stat.pre_done = 1'b1;
                     res_status_in = ST_ZERO_TAG;
                  end
               end
            end
         end
         OP_A_EVAL: begin
            base_tag_in  = eb_tag;
            base_size_in = eb_size;
            base_prev_in = eb_prev;
            start_in     = start_eff;
            first_in     = 1'b0;
            if (follow_ff && !first_ff && !((d_tag != '0) || (CW'(d_size) < need_ff))) begin
               stat.found = 1'b1;
            end else if ((cur_ff == start_eff) || (guard_ff > QW'(GRANS + 2))) begin
               stat.fail     = 1'b1;
               res_status_in = ST_NO_SPACE;
            end else begin
               guard_in = guard_ff + 1'b1;
               cur_in   = nxt;
               addr_in  = nxt;
               if (d_tag != '0) begin
                  base_in   = nxt;
                  follow_in = 1'b1;
               end else begin
                  follow_in = 1'b0;
                  if (!((eb_tag != '0) || (CW'(eb_size) < need_ff))) begin
                     stat.found = 1'b1;
                  end
               end
            end
         end
         OP_A_FOUND: begin
            if (CW'(extra) > CW'(min_frag_ff)) begin
               stat.split   = 1'b1;
               wr_en        = 1'b1;
               wr_addr      = nb;
               wr_data      = {1'b1, TAG_W'(0), extra, base_ff};
               link_in      = nb;
               addr_in      = next_of(base_ff, base_size_ff);
               base_size_in = SW'(need_ff);
            end
         end
         OP_A_BASE: begin
            wr_en        = 1'b1;
            wr_addr      = base_ff;
            wr_data      = {1'b1, tag_ff, base_size_ff, base_prev_ff};
            rover_in     = next_of(base_ff, base_size_ff);
            res_addr_in  = ua[ADDR_W-1:0];
            res_bytes_in = gb[BYTES_W-1:0];
         end
         OP_SETPREV: begin
            wr_en   = 1'b1;
            wr_data = {d_id, d_tag, d_size, link_ff};
            addr_in = next_of(g_ff, g_size_ff);
         end
         OP_F_CHK: begin
            if (!d_id) begin
               stat.chk_err  = 1'b1;
               res_status_in = ST_NOT_BLOCK;
            end else if (d_tag == '0) begin
               stat.chk_err  = 1'b1;
               res_status_in = ST_DOUBLE_FREE;
            end else begin
               wr_en     = 1'b1;
               wr_data   = {d_id, TAG_W'(0), d_size, d_prev};
               g_size_in = d_size;
               g_prev_in = d_prev;
               addr_in   = d_prev;
            end
         end
         OP_F_PREV: begin
            addr_in = next_of(g_ff, g_size_ff);
            if (d_tag == '0) begin
               stat.merge = 1'b1;
               nsz        = d_size + g_size_ff;
               wr_en      = 1'b1;
               wr_data    = {d_id, TAG_W'(0), nsz, d_prev};
               link_in    = addr_ff;
               if (rover_ff == g_ff) begin
                  rover_in = addr_ff;
               end
               g_in      = addr_ff;
               g_size_in = nsz;
               g_prev_in = d_prev;
            end
         end
         OP_F_NEXT: begin
            if (d_tag == '0) begin
               stat.merge = 1'b1;
               nsz        = g_size_ff + d_size;
               wr_en      = 1'b1;
               wr_addr    = g_ff;
               wr_data    = {1'b1, TAG_W'(0), nsz, g_prev_ff};
               link_in    = g_ff;
               addr_in    = next_of(addr_ff, d_size);
               g_size_in  = nsz;
               if (rover_ff == addr_ff) begin
                  rover_in = g_ff;
               end
            end
         end
         OP_DONE: begin
            if (stat.rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_bytes_in  = res_bytes_ff;
            end
         end
         default: begin
         end
      endcase

      if (wr_en && (wr_addr == GW'(SENT))) begin
         sent_prev_in = wr_data[GW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr != GW'(SENT))) begin
         mem[wr_addr[IW-1:0]] <= wr_data;
      end
      rd_ff <= mem[addr_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         rover_ff     <= '0;
         sent_prev_ff <= '0;
         min_frag_ff  <= MINFRAG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         rover_ff     <= rover_in;
         sent_prev_ff <= sent_prev_in;
         if (csr_wr_en) begin
            min_frag_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_sent_ff    <= (addr_ff == GW'(SENT));
      addr_ff       <= addr_in;
      need_ff       <= need_in;
      tag_ff        <= tag_in;
      cur_ff        <= cur_in;
      base_ff       <= base_in;
      start_ff      <= start_in;
      base_tag_ff   <= base_tag_in;
      base_size_ff  <= base_size_in;
      base_prev_ff  <= base_prev_in;
      first_ff      <= first_in;
      follow_ff     <= follow_in;
      guard_ff      <= guard_in;
      g_ff          <= g_in;
      g_size_ff     <= g_size_in;
      g_prev_ff     <= g_prev_in;
      link_ff       <= link_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_bytes_ff  <= res_bytes_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_bytes_ff  <= rsp_bytes_in;
   end

endmodule

>>> hw/rtl/zone_next_fit_allocator_top.sv
// allocate time grows with each block header visited by the next-fit walk and with a
// split; free time grows with merges; argument errors go straight to the completion step,
// header errors on free end after the header check; a waiting response holds completion
// throughput: one transaction at a time, the next request taken the cycle after the
// response register is loaded, so the header memory walk sets the rate
// reset: synchronous, active high; a clearing pass over all ZONE_BYTES/8 header words follows reset
`timescale 1ns / 1ps

module zone_next_fit_allocator_top import zna_pkg::*; #(
   parameter int ZONE_BYTES   = 65536,
   parameter int HEADER_BYTES = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   zna_req_if.sink              req_chan,
   zna_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [MINFRAG_W-1:0] csr_wr_data
);

   zna_cmd_type  cmd;
   zna_stat_type stat;

   zna_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   zna_datapath #(
      .ZONE_BYTES   (ZONE_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

`ifndef SYNTHESIS
   a_found_fail: assert property (@(posedge clock) disable iff (reset)
      !(stat.found && stat.fail))
      else $error("search reported fit and no space together");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != ST_OK)) |->
      ((rsp_chan.user_addr == '0) && (rsp_chan.granted_bytes == '0)))
      else $error("failed transaction carries a payload");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.op == OP_DONE))
      else $error("response raised outside the completion step");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import zna_pkg::*;

   localparam int ARENA   = 65536;
   localparam int HDR     = 24;
   localparam int GRANS   = ARENA / 8;
   localparam int SENT    = GRANS;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   user_addr;
      logic [BYTES_W-1:0]  granted_bytes;
   } zone_result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [MINFRAG_W-1:0] csr_wr_data;

   zna_req_if req_bus ();
   zna_rsp_if rsp_bus ();

   zone_next_fit_allocator_top #(.ZONE_BYTES(ARENA), .HEADER_BYTES(HDR)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0; #4;
      clock = 1'b1; #4;
   end

   // shadow of the header store
   bit          blk_id   [0:GRANS];
   logic [7:0]  blk_tag  [0:GRANS];
   int unsigned blk_size [0:GRANS];
   int unsigned blk_prev [0:GRANS];
   int unsigned rover_g;
   int unsigned min_frag;

   zone_result_type pending_q[$];
   int unsigned     live_q[$];
   int unsigned     dead_q[$];
   zone_result_type last_result;

   int errors, n_alloc, n_free, n_err, n_ok_alloc, n_ok_free;
   int hold_left, long_hold;
   bit idle_on;

   function automatic int unsigned next_blk(int unsigned g);
      int unsigned n;
      if (g >= SENT) return 0;
      n = g + blk_size[g] / 8;
      return (n > SENT) ? SENT : n;
   endfunction

   task automatic zone_clear();
      for (int i = 0; i <= GRANS; i++) begin
         blk_id[i] = 0; blk_tag[i] = 0; blk_size[i] = 0; blk_prev[i] = 0;
      end
      blk_id[0] = 1; blk_size[0] = GRANS * 8; blk_prev[0] = SENT;
      blk_id[SENT] = 1; blk_tag[SENT] = 1; blk_size[SENT] = 0; blk_prev[SENT] = 0;
      rover_g = 0;
      min_frag = MINFRAG_RESET;
   endtask

   function automatic zone_result_type zone_alloc(int unsigned req, logic [7:0] t);
      zone_result_type r;
      int unsigned need, base, cur, start, guard, extra, nb, old_next;
      r = '0;
      if (t == 0) begin
         r.status = ST_ZERO_TAG;
         return r;
      end
      need = (req + HDR + 4 + 7) & ~32'd7;
      base = rover_g; cur = rover_g; start = blk_prev[rover_g]; guard = 0;
      do begin
         if (cur == start || guard > GRANS + 2) begin
            r.status = ST_NO_SPACE;
            return r;
         end
         guard++;
         if (blk_tag[cur] != 0) begin
            cur = next_blk(cur);
            base = cur;
         end else begin
            cur = next_blk(cur);
         end
      end while (blk_tag[base] != 0 || blk_size[base] < need);
      extra = blk_size[base] - need;
      if (extra > min_frag) begin
         nb = base + need / 8;
         old_next = next_blk(base);
         blk_id[nb] = 1; blk_tag[nb] = 0; blk_size[nb] = extra; blk_prev[nb] = base;
         blk_prev[old_next] = nb;
         blk_size[base] = need;
      end
      blk_tag[base] = t;
      blk_id[base] = 1;
      rover_g = next_blk(base);
      r.status = ST_OK;
      r.user_addr = ADDR_W'(base * 8 + HDR);
      r.granted_bytes = BYTES_W'(blk_size[base]);
      return r;
   endfunction

   function automatic zone_result_type zone_free(int unsigned addr);
      zone_result_type r;
      int unsigned g, other, nx;
      r = '0;
      if (addr == 0) begin
         r.status = ST_NULL;
         return r;
      end
      if (addr < HDR || ((addr - HDR) & 7) != 0) begin
         r.status = ST_NOT_BLOCK;
         return r;
      end
      g = (addr - HDR) / 8;
      if (g >= GRANS || !blk_id[g]) begin
         r.status = ST_NOT_BLOCK;
         return r;
      end
      if (blk_tag[g] == 0) begin
         r.status = ST_DOUBLE_FREE;
         return r;
      end
      blk_tag[g] = 0;
      other = blk_prev[g];
      if (blk_tag[other] == 0) begin
         nx = next_blk(g);
         blk_size[other] += blk_size[g];
         blk_prev[nx] = other;
         if (rover_g == g) rover_g = other;
         g = other;
      end
      other = next_blk(g);
      if (blk_tag[other] == 0) begin
         nx = next_blk(other);
         blk_size[g] += blk_size[other];
         blk_prev[nx] = g;
         if (rover_g == other) rover_g = g;
      end
      r.status = ST_OK;
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      errors++;
      if (errors <= 40) $display("tb: mismatch on %s: got %0d, want %0d", what, got, want);
   endtask

   // one transaction into the block, prediction taken at acceptance
   task automatic send_req(logic [FUNC_W-1:0] f, int unsigned sz, logic [7:0] t,
                           int unsigned addr);
      zone_result_type p;
      int idx;
      req_bus.valid      <= 1'b1;
      req_bus.func       <= f;
      req_bus.req_size   <= SIZE_W'(sz);
      req_bus.alloc_tag  <= t;
      req_bus.block_addr <= ADDR_W'(addr);
      do @(posedge clock); while (!req_bus.ready);
      if (f == FUNC_ALLOC) begin
         p = zone_alloc(sz & 32'h1FFFF, t);
         n_alloc++;
         if (p.status == ST_OK) begin
            n_ok_alloc++;
            live_q.push_back(p.user_addr);
         end else n_err++;
      end else begin
         p = zone_free(addr & 32'hFFFF);
         n_free++;
         if (p.status == ST_OK) begin
            n_ok_free++;
            idx = -1;
            foreach (live_q[i]) if (live_q[i] == addr) idx = i;
            if (idx >= 0) live_q.delete(idx);
            dead_q.push_back(addr);
            if (dead_q.size() > 32) void'(dead_q.pop_front());
         end else n_err++;
      end
      last_result = p;
      pending_q.push_back(p);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_min_frag(int unsigned v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= MINFRAG_W'(v);
      @(posedge clock);
      min_frag = v & 32'h1FFFF;
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_item();
      int r, k;
      r = $urandom_range(0, 99);
      if (r < 6) begin
         case ($urandom_range(0, 3))
            0: send_req(FUNC_FREE, $urandom, 8'($urandom), $urandom_range(0, 65535));
            1: send_req(FUNC_ALLOC, $urandom_range(0, 131071), 8'd0, $urandom);
            2: send_req(FUNC_ALLOC, $urandom_range(65536, 131071),
                        8'($urandom_range(1, 255)), $urandom);
            default: send_req(FUNC_FREE, $urandom, 8'($urandom), 0);
         endcase
      end else if (r < 10 && dead_q.size() != 0) begin
         k = $urandom_range(0, dead_q.size() - 1);
         send_req(FUNC_FREE, $urandom, 8'($urandom), dead_q[k]);
      end else if (r < 52 && live_q.size() != 0) begin
         k = $urandom_range(0, live_q.size() - 1);
         send_req(FUNC_FREE, $urandom, 8'($urandom), live_q[k]);
      end else begin
         k = $urandom_range(0, 99);
         send_req(FUNC_ALLOC,
                  (k < 80) ? $urandom_range(0, 256) :
                  (k < 96) ? $urandom_range(0, 4096) : $urandom_range(0, 65536),
                  8'($urandom_range(1, 255)), $urandom);
      end
   endtask

   // response side: random stalls plus an optional long hold-off
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold > 0) begin
            long_hold--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(1, 12) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      zone_result_type w;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_q.size() == 0) begin
               report("unexpected transaction", rsp_bus.status, -1);
            end else begin
               w = pending_q.pop_front();
               if (rsp_bus.status !== w.status) report("status", rsp_bus.status, w.status);
               if (rsp_bus.user_addr !== w.user_addr)
                  report("user_addr", rsp_bus.user_addr, w.user_addr);
               if (rsp_bus.granted_bytes !== w.granted_bytes)
                  report("granted_bytes", rsp_bus.granted_bytes, w.granted_bytes);
            end
         end
      end
   end

   task automatic test_directed();
      int unsigned a, b;
      send_req(FUNC_ALLOC, 65508, 8'd255, 0);   // whole arena
      a = last_result.user_addr;
      send_req(FUNC_ALLOC, 0, 8'd1, 0);         // no space
      send_req(FUNC_FREE, 0, 0, a);
      send_req(FUNC_ALLOC, 40, 8'd0, 0);        // zero tag
      send_req(FUNC_FREE, 0, 0, 0);             // null
      send_req(FUNC_FREE, 0, 0, 1);
      send_req(FUNC_FREE, 0, 0, 25);
      send_req(FUNC_FREE, 0, 0, 65528);         // granule never a header
      send_req(FUNC_FREE, 0, 0, 65535);
      send_req(FUNC_ALLOC, 0, 8'd7, 0);
      a = last_result.user_addr;
      send_req(FUNC_ALLOC, 100, 8'd8, 0);
      b = last_result.user_addr;
      send_req(FUNC_ALLOC, 131071, 8'd9, 0);
      send_req(FUNC_ALLOC, 65536, 8'd170, 0);
      send_req(FUNC_ALLOC, 65535, 8'd85, 0);
      send_req(FUNC_FREE, 0, 0, a);
      send_req(FUNC_FREE, 0, 0, b);             // merges into previous
      send_req(FUNC_FREE, 0, 0, b);             // retired header
      send_req(FUNC_FREE, 0, 0, a);             // free block
      send_req(FUNC_ALLOC, 1000, 8'd128, 0);
      send_req(FUNC_ALLOC, 16, 8'd1, 0);
      drain();
   endtask

   task automatic test_random(int n);
      repeat (n) random_item();
      drain();
   endtask

   task automatic test_backpressure();
      long_hold = 600;
      repeat (40) random_item();
      drain();
      repeat (10) random_item();
      drain();
   endtask

   initial begin
      errors = 0; n_alloc = 0; n_free = 0; n_err = 0; n_ok_alloc = 0; n_ok_free = 0;
      hold_left = 0; long_hold = 0; idle_on = 1;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.func       <= FUNC_ALLOC;
      req_bus.req_size   <= '0;
      req_bus.alloc_tag  <= '0;
      req_bus.block_addr <= '0;
      zone_clear();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      set_min_frag(0);
      test_random(200);
      set_min_frag(65536);
      test_random(120);
      set_min_frag(131071);
      test_random(60);
      set_min_frag($urandom_range(8, 512));
      test_random(180);
      test_backpressure();
      set_min_frag(64);
      idle_on = 0;
      test_random(230);

      $display("tb: %0d allocates (%0d granted), %0d frees (%0d ok), %0d error statuses",
               n_alloc, n_ok_alloc, n_free, n_ok_free, n_err);
      $display("tb: min_fragment swept over 0, 64, 65536, 131071 and a random value");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #1_000_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
